// File: design/nic_pkg.sv
package nic_pkg;

	localparam int IN_FRAC_BITS_DEF  = 30;
	localparam int OUT_FRAC_BITS_DEF = 16;

	localparam int QF        = 28;	// fraction bits of the internal path
	localparam int PROB_W    = 32;
	localparam int Q_W       = 40;
	localparam int ST_W      = 2;
	localparam int MEAN_W    = 32;
	localparam int STDEV_W   = 31;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 32;

	localparam int M_W   = 32;	// log mantissa
	localparam int N_W   = 5;	// leading one position
	localparam int NL_W  = 34;	// -log2 in Q.28
	localparam int X_W   = 64;	// square root working width
	localparam int T_W   = 31;
	localparam int NUM_W = 32;
	localparam int DEN_W = 33;
	localparam int DQ_W  = 32;	// dividend low bits / quotient

	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = DQ_W;

	localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;
	localparam logic [63:0] K_C0 = 64'd675253953;
	localparam logic [63:0] K_C1 = 64'd215514211;
	localparam logic [63:0] K_C2 = 64'd2772401;
	localparam logic [63:0] K_D1 = 64'd384611100;
	localparam logic [63:0] K_D2 = 64'd50806510;
	localparam logic [63:0] K_D3 = 64'd351114;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_END   = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MEAN  = 2'd0,
		REG_STDEV = 2'd1
	} reg_idx_t;

	typedef enum logic [2:0] {
		K_NORM,
		K_RANGE,
		K_LOW,
		K_HIGH,
		K_HALF
	} kind_t;

	// control that travels with every item down the chain
	typedef struct packed {
		logic  vld;
		kind_t kind;
		logic  neg;
	} side_t;

endpackage

// File: design/nic_if.sv
interface nic_in_if;
	logic                             valid;
	logic                             ready;
	logic signed [nic_pkg::PROB_W-1:0] prob;
	modport source (output valid, output prob, input ready);
	modport sink (input valid, input prob, output ready);
endinterface

interface nic_out_if;
	logic                          valid;
	logic                          ready;
	logic signed [nic_pkg::Q_W-1:0] quantile;
	logic [nic_pkg::ST_W-1:0]       status;
	modport source (output valid, output quantile, output status, input ready);
	modport sink (input valid, input quantile, input status, output ready);
endinterface

interface nic_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [nic_pkg::CFG_IDX_W-1:0]   index;
	logic [nic_pkg::CFG_DAT_W-1:0]   data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/normal_inverse_cdf.sv
// Normal quantile, one item per cycle when the output is taken.
// Pipeline: 102 registers from input to result: 2 decode, 28 log cells,
// 2 scale, 32 square-root cells, 3 polynomial, 32 divider cells, 2 final,
// 1 output.
// Throughput: 1 item/cycle; the chain stalls only when the output register
// holds an untaken result and the last stage carries an item.
// Reset (arst_n low, async): all valid bits clear, mean = 0, stdev = 1.0.
module normal_inverse_cdf #(
	parameter int IN_FRAC_BITS  = nic_pkg::IN_FRAC_BITS_DEF,
	parameter int OUT_FRAC_BITS = nic_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	nic_in_if.sink      sample,
	nic_out_if.source   result,
	nic_cfg_if.sink     cfg
);
	localparam int QF = nic_pkg::QF;
	localparam int SR  = 44 - OUT_FRAC_BITS;		// product Q.44 to output scale
	localparam int MUP = (OUT_FRAC_BITS >= 16) ? OUT_FRAC_BITS - 16 : 0;
	localparam int MDN = (OUT_FRAC_BITS < 16) ? 16 - OUT_FRAC_BITS : 0;
	localparam int SW  = 66;						// final sum width
	localparam logic signed [33:0] ONE = 34'sd1 <<< IN_FRAC_BITS;
	localparam logic signed [SW-1:0] QMAX = (66'sd1 <<< (nic_pkg::Q_W - 1)) - 66'sd1;
	localparam logic signed [SW-1:0] QMIN = -(66'sd1 <<< (nic_pkg::Q_W - 1));

	// ---------------- configuration registers ----------------
	logic signed [nic_pkg::MEAN_W-1:0] mean_q;
	logic [nic_pkg::STDEV_W-1:0]       stdev_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q  <= '0;
			stdev_q <= 31'd65536;
		end else if (cfg.valid) begin
			unique case (nic_pkg::reg_idx_t'(cfg.index))
				nic_pkg::REG_MEAN:  mean_q  <= cfg.data;
				nic_pkg::REG_STDEV: stdev_q <= cfg.data[nic_pkg::STDEV_W-1:0];
				default: ;	// unmapped index, ignored
			endcase
		end
	end

	// ---------------- flow control ----------------
	// All stages move together. The chain may advance whenever the last stage
	// is empty or the output register can take its item.
	nic_pkg::side_t ms_side_s1;
	logic           res_vld_q;
	logic           adv;
	logic           load;

	assign adv          = !ms_side_s1.vld || !res_vld_q || result.ready;
	assign load         = ms_side_s1.vld && adv;
	assign sample.ready = adv;

	// ---------------- stage 1: classify, fold p = min(u, 1-u) ----------------
	logic signed [33:0] u;
	logic signed [33:0] pv;
	nic_pkg::side_t     s1_side_n;
	nic_pkg::side_t     dc_side_s1;
	logic [31:0]        dc_p_s1;

	always_comb begin
		u = {{2{sample.prob[31]}}, sample.prob};
		s1_side_n.vld = sample.valid;
		s1_side_n.neg = (u <<< 1) < ONE;
		priority if (u < 0 || u > ONE) begin
			s1_side_n.kind = nic_pkg::K_RANGE;
		end else if (u == 0) begin
			s1_side_n.kind = nic_pkg::K_LOW;
		end else if (u == ONE) begin
			s1_side_n.kind = nic_pkg::K_HIGH;
		end else if ((u <<< 1) == ONE) begin
			s1_side_n.kind = nic_pkg::K_HALF;
		end else begin
			s1_side_n.kind = nic_pkg::K_NORM;
		end
		pv = s1_side_n.neg ? u : ONE - u;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_side_s1 <= '0;
		end else if (adv) begin
			dc_side_s1 <= s1_side_n;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dc_p_s1 <= pv[31:0];
		end
	end

	// ---------------- stage 2: leading one, normalize mantissa ----------------
	logic [nic_pkg::N_W-1:0] lz_n;
	nic_pkg::side_t          nm_side_s2;
	logic [nic_pkg::M_W-1:0] nm_m_s2;
	logic [nic_pkg::N_W-1:0] nm_n_s2;

	always_comb begin
		lz_n = '0;
		for (int i = 0; i < 32; i++) begin
			if (dc_p_s1[i]) begin
				lz_n = nic_pkg::N_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nm_side_s2 <= '0;
		end else if (adv) begin
			nm_side_s2 <= dc_side_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nm_m_s2 <= dc_p_s1 << (5'd31 - lz_n);
			nm_n_s2 <= lz_n;
		end
	end

	// ---------------- log2 chain: one fraction bit per cell ----------------
	nic_pkg::side_t          lg_side [0:QF];
	logic [nic_pkg::M_W-1:0] lg_m    [0:QF];
	logic [QF-1:0]           lg_frac [0:QF];
	logic [nic_pkg::N_W-1:0] lg_n    [0:QF];

	assign lg_side[0] = nm_side_s2;
	assign lg_m[0]    = nm_m_s2;
	assign lg_frac[0] = '0;
	assign lg_n[0]    = nm_n_s2;

	for (genvar k = 0; k < QF; k++) begin : g_log
		nic_log_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.side_i (lg_side[k]),
			.m_i    (lg_m[k]),
			.frac_i (lg_frac[k]),
			.n_i    (lg_n[k]),
			.side_o (lg_side[k+1]),
			.m_o    (lg_m[k+1]),
			.frac_o (lg_frac[k+1]),
			.n_o    (lg_n[k+1])
		);
	end

	// ---------------- scale: L = -log2(p) * 2 ln2, Q.56 ----------------
	nic_pkg::side_t           nl_side_s1;
	logic [nic_pkg::NL_W-1:0] nl_s1;
	nic_pkg::side_t           ll_side_s2;
	logic [nic_pkg::X_W-1:0]  ll_s2;
	logic [64:0]              ll_prod;

	assign ll_prod = {31'd0, nl_s1} * {34'd0, nic_pkg::TWO_LN2_Q30};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nl_side_s1 <= '0;
			ll_side_s2 <= '0;
		end else if (adv) begin
			nl_side_s1 <= lg_side[QF];
			ll_side_s2 <= nl_side_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nl_s1 <= ((nic_pkg::NL_W'(IN_FRAC_BITS) - nic_pkg::NL_W'(lg_n[QF])) << QF)
				- nic_pkg::NL_W'(lg_frac[QF]);
			ll_s2 <= {2'b00, ll_prod[63:2]};
		end
	end

	// ---------------- square root chain: one result bit per cell ----------------
	nic_pkg::side_t          sq_side [0:nic_pkg::SQRT_STEPS];
	logic [nic_pkg::X_W-1:0] sq_x    [0:nic_pkg::SQRT_STEPS];
	logic [nic_pkg::X_W-1:0] sq_res  [0:nic_pkg::SQRT_STEPS];

	assign sq_side[0] = ll_side_s2;
	assign sq_x[0]    = ll_s2;
	assign sq_res[0]  = '0;

	for (genvar k = 0; k < nic_pkg::SQRT_STEPS; k++) begin : g_sqrt
		nic_sqrt_cell #(
			.SH (62 - 2 * k)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.side_i (sq_side[k]),
			.x_i    (sq_x[k]),
			.res_i  (sq_res[k]),
			.side_o (sq_side[k+1]),
			.x_o    (sq_x[k+1]),
			.res_o  (sq_res[k+1])
		);
	end

	// ---------------- rational polynomial, Horner over three stages ----------------
	logic [nic_pkg::T_W-1:0]   t_sq;
	nic_pkg::side_t            hp_side_s1, hp_side_s2, hp_side_s3;
	logic [nic_pkg::T_W-1:0]   hp_t_s1, hp_t_s2, hp_t_s3;
	logic [31:0]               hp_a_s1, hp_e_s1;
	logic [31:0]               hp_b_s2, hp_f_s2;
	logic [nic_pkg::NUM_W-1:0] hp_num_s3;
	logic [nic_pkg::DEN_W-1:0] hp_den_s3;
	logic [63:0]               pa, pe, pb, pf, pg;

	assign t_sq = sq_res[nic_pkg::SQRT_STEPS][nic_pkg::T_W-1:0];

	always_comb begin
		pa = nic_pkg::K_C2 * {33'd0, t_sq};
		pe = nic_pkg::K_D3 * {33'd0, t_sq};
		pb = ({32'd0, hp_a_s1} + nic_pkg::K_C1) * {33'd0, hp_t_s1};
		pf = ({32'd0, hp_e_s1} + nic_pkg::K_D2) * {33'd0, hp_t_s1};
		pg = ({32'd0, hp_f_s2} + nic_pkg::K_D1) * {33'd0, hp_t_s2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_side_s1 <= '0;
			hp_side_s2 <= '0;
			hp_side_s3 <= '0;
		end else if (adv) begin
			hp_side_s1 <= sq_side[nic_pkg::SQRT_STEPS];
			hp_side_s2 <= hp_side_s1;
			hp_side_s3 <= hp_side_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hp_t_s1   <= t_sq;
			hp_a_s1   <= pa[QF+31:QF];
			hp_e_s1   <= pe[QF+31:QF];
			hp_t_s2   <= hp_t_s1;
			hp_b_s2   <= pb[QF+31:QF];
			hp_f_s2   <= pf[QF+31:QF];
			hp_t_s3   <= hp_t_s2;
			hp_num_s3 <= hp_b_s2 + nic_pkg::K_C0[31:0];
			hp_den_s3 <= pg[QF+nic_pkg::DEN_W-1:QF] + (33'd1 << QF);
		end
	end

	// ---------------- divider chain: r = num * 2^28 / den ----------------
	// Quotient fits 32 bits, so the top of the dividend seeds the remainder.
	nic_pkg::side_t            dv_side [0:nic_pkg::DIV_STEPS];
	logic [nic_pkg::DEN_W-1:0] dv_rem  [0:nic_pkg::DIV_STEPS];
	logic [nic_pkg::DQ_W-1:0]  dv_dq   [0:nic_pkg::DIV_STEPS];
	logic [nic_pkg::DEN_W-1:0] dv_den  [0:nic_pkg::DIV_STEPS];
	logic [nic_pkg::T_W-1:0]   dv_t    [0:nic_pkg::DIV_STEPS];

	assign dv_side[0] = hp_side_s3;
	assign dv_rem[0]  = {5'd0, hp_num_s3[31:4]};
	assign dv_dq[0]   = {hp_num_s3[3:0], {QF{1'b0}}};
	assign dv_den[0]  = hp_den_s3;
	assign dv_t[0]    = hp_t_s3;

	for (genvar k = 0; k < nic_pkg::DIV_STEPS; k++) begin : g_div
		nic_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.side_i (dv_side[k]),
			.rem_i  (dv_rem[k]),
			.dq_i   (dv_dq[k]),
			.den_i  (dv_den[k]),
			.t_i    (dv_t[k]),
			.side_o (dv_side[k+1]),
			.rem_o  (dv_rem[k+1]),
			.dq_o   (dv_dq[k+1]),
			.den_o  (dv_den[k+1]),
			.t_o    (dv_t[k+1])
		);
	end

	// ---------------- z = t - r, magnitude and sign; then times stdev ----------------
	logic signed [33:0] z;
	logic [33:0]        zmag;
	nic_pkg::side_t     zs_side_n;
	nic_pkg::side_t     zs_side_s1;
	logic [31:0]        zs_mag_s1;
	logic [62:0]        ms_prod_s1;

	always_comb begin
		z = $signed({3'b000, dv_t[nic_pkg::DIV_STEPS]})
			- $signed({2'b00, dv_dq[nic_pkg::DIV_STEPS]});
		zmag = (z < 0) ? 34'(-z) : 34'(z);
		zs_side_n = dv_side[nic_pkg::DIV_STEPS];
		zs_side_n.neg = dv_side[nic_pkg::DIV_STEPS].neg ^ (z < 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zs_side_s1 <= '0;
			ms_side_s1 <= '0;
		end else if (adv) begin
			zs_side_s1 <= zs_side_n;
			ms_side_s1 <= zs_side_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			zs_mag_s1  <= zmag[31:0];
			ms_prod_s1 <= {31'd0, zs_mag_s1} * {32'd0, stdev_q};
		end
	end

	// ---------------- round, sign, add mean, saturate; special kinds override ----------------
	logic [63:0]              scaled;
	logic signed [SW-1:0]     term;
	logic signed [SW-1:0]     mterm;
	logic signed [SW-1:0]     sum;
	logic signed [SW-1:0]     qsel;
	nic_pkg::status_t         st_n;
	logic signed [nic_pkg::Q_W-1:0] quantile_q;
	logic [nic_pkg::ST_W-1:0]       status_q;

	always_comb begin
		scaled = ({1'b0, ms_prod_s1} + (64'd1 << (SR - 1))) >> SR;
		term   = ms_side_s1.neg ? -$signed({2'b00, scaled}) : $signed({2'b00, scaled});
		mterm  = ($signed({{(SW-nic_pkg::MEAN_W){mean_q[nic_pkg::MEAN_W-1]}}, mean_q})
			<<< MUP) >>> MDN;
		sum    = mterm + term;
		st_n   = nic_pkg::ST_OK;
		unique case (ms_side_s1.kind)
			nic_pkg::K_RANGE: begin
				qsel = '0;
				st_n = nic_pkg::ST_RANGE;
			end
			nic_pkg::K_LOW: begin
				qsel = QMIN;
				st_n = nic_pkg::ST_END;
			end
			nic_pkg::K_HIGH: begin
				qsel = QMAX;
				st_n = nic_pkg::ST_END;
			end
			nic_pkg::K_HALF: begin
				qsel = mterm;
			end
			default: begin
				qsel = (sum > QMAX) ? QMAX : ((sum < QMIN) ? QMIN : sum);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (load) begin
			res_vld_q <= 1'b1;
		end else if (result.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			quantile_q <= qsel[nic_pkg::Q_W-1:0];
			status_q   <= st_n;
		end
	end

	assign result.valid    = res_vld_q;
	assign result.quantile = quantile_q;
	assign result.status   = status_q;

	// ---------------- checks ----------------
	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.status == nic_pkg::ST_RANGE |-> result.quantile == '0)
		else $error("out-of-range item with nonzero quantile");

	a_end_sat: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.status == nic_pkg::ST_END
		|-> (result.quantile == QMAX[nic_pkg::Q_W-1:0]
			|| result.quantile == QMIN[nic_pkg::Q_W-1:0]))
		else $error("endpoint item not saturated");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> result.valid && !result.ready && ms_side_s1.vld)
		else $error("chain stalled without a blocked result");

	a_last_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ms_side_s1.vld && !adv |=> ms_side_s1.vld)
		else $error("item lost from last stage during stall");
endmodule

// File: design/nic_log_cell.sv
// One fraction bit of log2 by squaring the mantissa.
module nic_log_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  nic_pkg::side_t           side_i,
	input  logic [nic_pkg::M_W-1:0]  m_i,
	input  logic [nic_pkg::QF-1:0]   frac_i,
	input  logic [nic_pkg::N_W-1:0]  n_i,
	output nic_pkg::side_t           side_o,
	output logic [nic_pkg::M_W-1:0]  m_o,
	output logic [nic_pkg::QF-1:0]   frac_o,
	output logic [nic_pkg::N_W-1:0]  n_o
);
	logic [2*nic_pkg::M_W-1:0] sq;
	logic [nic_pkg::M_W:0]     sh;
	logic [nic_pkg::M_W-1:0]   m_n;

	always_comb begin
		sq = {{nic_pkg::M_W{1'b0}}, m_i} * {{nic_pkg::M_W{1'b0}}, m_i};
		sh = sq[2*nic_pkg::M_W-1:nic_pkg::M_W-1];
		m_n = sh[nic_pkg::M_W] ? sh[nic_pkg::M_W:1] : sh[nic_pkg::M_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_o <= '0;
		end else if (en) begin
			side_o <= side_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_o    <= m_n;
			frac_o <= {frac_i[nic_pkg::QF-2:0], sh[nic_pkg::M_W]};
			n_o    <= n_i;
		end
	end
endmodule

// File: design/nic_sqrt_cell.sv
// One result bit of the integer square root.
module nic_sqrt_cell #(
	parameter int SH = 62
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  nic_pkg::side_t           side_i,
	input  logic [nic_pkg::X_W-1:0]  x_i,
	input  logic [nic_pkg::X_W-1:0]  res_i,
	output nic_pkg::side_t           side_o,
	output logic [nic_pkg::X_W-1:0]  x_o,
	output logic [nic_pkg::X_W-1:0]  res_o
);
	localparam logic [nic_pkg::X_W-1:0] BITV = {{(nic_pkg::X_W-1){1'b0}}, 1'b1} << SH;

	logic [nic_pkg::X_W-1:0] trial;
	logic                    ge;

	always_comb begin
		trial = res_i + BITV;
		ge    = x_i >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_o <= '0;
		end else if (en) begin
			side_o <= side_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_o   <= ge ? x_i - trial : x_i;
			res_o <= ge ? (res_i >> 1) + BITV : res_i >> 1;
		end
	end
endmodule

// File: design/nic_div_cell.sv
// One quotient bit of restoring division; dividend bits leave dq at the top,
// quotient bits enter at the bottom.
module nic_div_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  nic_pkg::side_t             side_i,
	input  logic [nic_pkg::DEN_W-1:0]  rem_i,
	input  logic [nic_pkg::DQ_W-1:0]   dq_i,
	input  logic [nic_pkg::DEN_W-1:0]  den_i,
	input  logic [nic_pkg::T_W-1:0]    t_i,
	output nic_pkg::side_t             side_o,
	output logic [nic_pkg::DEN_W-1:0]  rem_o,
	output logic [nic_pkg::DQ_W-1:0]   dq_o,
	output logic [nic_pkg::DEN_W-1:0]  den_o,
	output logic [nic_pkg::T_W-1:0]    t_o
);
	logic [nic_pkg::DEN_W:0] rem2;
	logic [nic_pkg::DEN_W:0] diff;
	logic                    ge;

	always_comb begin
		rem2 = {rem_i, dq_i[nic_pkg::DQ_W-1]};
		diff = rem2 - {1'b0, den_i};
		ge   = rem2 >= {1'b0, den_i};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_o <= '0;
		end else if (en) begin
			side_o <= side_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= ge ? diff[nic_pkg::DEN_W-1:0] : rem2[nic_pkg::DEN_W-1:0];
			dq_o  <= {dq_i[nic_pkg::DQ_W-2:0], ge};
			den_o <= den_i;
			t_o   <= t_i;
		end
	end
endmodule
